### rtl/core/ring_resource_arbiter_defines.svh
// Assertion helpers for the ring resource arbiter checks.
`ifndef RING_RESOURCE_ARBITER_DEFINES_SVH
`define RING_RESOURCE_ARBITER_DEFINES_SVH

// same-cycle implication
`define RRA_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("rra check failed");

// next-cycle implication
`define RRA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("rra check failed");

`endif

### rtl/core/rra_pkg.sv
`default_nettype none

package rra_pkg;

    localparam int DEF_MAX_SEATS = 16;
    localparam int MIN_SEATS     = 2;
    localparam int SEAT_W        = 4;
    localparam int COUNT_W       = 5;
    localparam int OPQ_DEPTH     = 2;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd5;

    localparam logic MODE_TAKE    = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

endpackage

`default_nettype wire

### rtl/core/rra_opq.sv
`default_nettype none

module rra_opq
    import rra_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = OPQ_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  empty,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/core/rra_front.sv
`default_nettype none

module rra_front
    import rra_pkg::*;
#(
    parameter int MAX_SEATS = DEF_MAX_SEATS,
    parameter int IDX_W     = $clog2(MAX_SEATS),
    parameter int OP_W      = 1 + 4 * IDX_W
)
(
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               mode,
    input  wire logic [SEAT_W-1:0]  seat_index,
    input  wire logic [COUNT_W-1:0] seat_count,
    input  wire logic               q_full,
    output logic                    q_push,
    output logic [OP_W-1:0]         q_data
);

    localparam int RING_W = $clog2(MAX_SEATS + 1);
    localparam int CMP_W  = (RING_W > COUNT_W) ? RING_W : COUNT_W;

    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] ring_n;
    logic             in_range;
    logic [IDX_W-1:0] nm1;
    logic [IDX_W-1:0] seat_i;
    logic [IDX_W-1:0] lft;
    logic [IDX_W-1:0] rgt;

    assign cnt_ext = CMP_W'(seat_count);

    // clamp the ring size to what is built
    always_comb
    begin
        priority if (cnt_ext < CMP_W'(MIN_SEATS))
        begin
            ring_n = CMP_W'(MIN_SEATS);
        end
        else if (cnt_ext > CMP_W'(MAX_SEATS))
        begin
            ring_n = CMP_W'(MAX_SEATS);
        end
        else
        begin
            ring_n = cnt_ext;
        end
    end

    assign in_range = (CMP_W'(seat_index) < ring_n);
    assign nm1      = IDX_W'(ring_n - CMP_W'(1));
    assign seat_i   = IDX_W'(seat_index);
    assign lft      = (seat_i == '0) ? nm1 : seat_i - IDX_W'(1);
    assign rgt      = (seat_i == nm1) ? '0 : seat_i + IDX_W'(1);

    // out-of-range beats are taken and dropped here
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full && in_range;
    assign q_data   = {mode, seat_i, lft, rgt, nm1};

endmodule

`default_nettype wire

### rtl/core/rra_back.sv
`default_nettype none

module rra_back
    import rra_pkg::*;
#(
    parameter int MAX_SEATS = DEF_MAX_SEATS,
    parameter int IDX_W     = $clog2(MAX_SEATS),
    parameter int OP_W      = 1 + 4 * IDX_W
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              op_valid,
    input  wire logic [OP_W-1:0]   op_data,
    output logic                   op_pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [SEAT_W-1:0]      granted_seat,
    output logic                   last
);

    typedef enum logic [1:0] {
        BK_IDLE  = 2'b01,
        BK_RIGHT = 2'b10
    } bk_state_t;

    bk_state_t            state_reg, state_next;
    logic [MAX_SEATS-1:0] hungry_reg, hungry_next;
    logic [MAX_SEATS-1:0] eat_reg, eat_next;
    logic [1:0]           out_cnt_reg, out_cnt_next;
    logic                 head_reg, head_next;
    logic                 g0_reg, g0_next;
    logic [IDX_W-1:0]     lft_reg, lft_next;
    logic [IDX_W-1:0]     rgt_reg, rgt_next;
    logic [IDX_W-1:0]     nm1_reg, nm1_next;
    logic [IDX_W-1:0]     buf_seat_reg [2];
    logic [IDX_W-1:0]     buf_seat_next [2];
    logic                 buf_last_reg [2];
    logic                 buf_last_next [2];

    logic                 op_rel;
    logic [IDX_W-1:0]     op_seat;
    logic [IDX_W-1:0]     op_lft;
    logic [IDX_W-1:0]     op_rgt;
    logic [IDX_W-1:0]     op_nm1;
    logic [MAX_SEATS-1:0] seat_oh;
    logic [MAX_SEATS-1:0] hv_take;
    logic [MAX_SEATS-1:0] ev_take;
    logic [MAX_SEATS-1:0] hv_rel;
    logic [MAX_SEATS-1:0] ev_rel;
    logic [MAX_SEATS-1:0] g_take;
    logic [MAX_SEATS-1:0] g_rel;
    logic [MAX_SEATS-1:0] g_cur;
    logic [MAX_SEATS-1:0] lft_oh;
    logic [MAX_SEATS-1:0] rgt_oh;
    logic                 start;

    // one cell per seat: hungry and neither neighbor eating
    function automatic logic [MAX_SEATS-1:0] grantable(
        input logic [MAX_SEATS-1:0] hv,
        input logic [MAX_SEATS-1:0] ev,
        input logic [IDX_W-1:0]     nm1
    );
        logic [MAX_SEATS-1:0] g;
        logic                 le;
        logic                 re;
        for (int k = 0; k < MAX_SEATS; k++)
        begin
            le   = (k == 0) ? ev[nm1] : ev[(k + MAX_SEATS - 1) % MAX_SEATS];
            re   = (IDX_W'(k) == nm1) ? ev[0] : ev[(k + 1) % MAX_SEATS];
            g[k] = hv[k] && !le && !re;
        end
        return g;
    endfunction

    assign op_rel  = op_data[OP_W-1];
    assign op_seat = op_data[4*IDX_W-1 -: IDX_W];
    assign op_lft  = op_data[3*IDX_W-1 -: IDX_W];
    assign op_rgt  = op_data[2*IDX_W-1 -: IDX_W];
    assign op_nm1  = op_data[IDX_W-1:0];

    assign seat_oh = MAX_SEATS'(1) << op_seat;
    assign lft_oh  = MAX_SEATS'(1) << op_lft;
    assign rgt_oh  = MAX_SEATS'(1) << rgt_reg;

    assign hv_take = hungry_reg | seat_oh;
    assign ev_take = eat_reg & ~seat_oh;
    assign hv_rel  = hungry_reg & ~seat_oh;
    assign ev_rel  = eat_reg & ~seat_oh;
    assign g_take  = grantable(hv_take, ev_take, op_nm1);
    assign g_rel   = grantable(hv_rel, ev_rel, op_nm1);
    assign g_cur   = grantable(hungry_reg, eat_reg, nm1_reg);

    // next op starts only once the result buffer has drained
    assign start  = (state_reg == BK_IDLE) && op_valid && (out_cnt_reg == 2'd0);
    assign op_pop = start;

    assign out_valid    = (out_cnt_reg != 2'd0);
    assign granted_seat = SEAT_W'(buf_seat_reg[head_reg]);
    assign last         = buf_last_reg[head_reg];

    always_comb
    begin
        state_next       = state_reg;
        hungry_next      = hungry_reg;
        eat_next         = eat_reg;
        out_cnt_next     = out_cnt_reg;
        head_next        = head_reg;
        g0_next          = g0_reg;
        lft_next         = lft_reg;
        rgt_next         = rgt_reg;
        nm1_next         = nm1_reg;
        buf_seat_next[0] = buf_seat_reg[0];
        buf_seat_next[1] = buf_seat_reg[1];
        buf_last_next[0] = buf_last_reg[0];
        buf_last_next[1] = buf_last_reg[1];

        if (out_valid && !out_stall)
        begin
            head_next    = !head_reg;
            out_cnt_next = out_cnt_reg - 2'd1;
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                if (start)
                begin
                    if (op_rel == MODE_RELEASE)
                    begin
                        hungry_next = hv_rel;
                        eat_next    = ev_rel;
                        if (g_rel[op_lft])
                        begin
                            hungry_next = hv_rel & ~lft_oh;
                            eat_next    = ev_rel | lft_oh;
                        end
                        g0_next    = g_rel[op_lft];
                        lft_next   = op_lft;
                        rgt_next   = op_rgt;
                        nm1_next   = op_nm1;
                        state_next = BK_RIGHT;
                    end
                    else if (g_take[op_seat])
                    begin
                        hungry_next      = hv_take & ~seat_oh;
                        eat_next         = ev_take | seat_oh;
                        buf_seat_next[0] = op_seat;
                        buf_last_next[0] = 1'b1;
                        out_cnt_next     = 2'd1;
                        head_next        = 1'b0;
                    end
                    else
                    begin
                        hungry_next = hv_take;
                        eat_next    = ev_take;
                    end
                end
            end
            BK_RIGHT:
            begin
                // right test sees the left grant already in place
                if (g_cur[rgt_reg])
                begin
                    hungry_next = hungry_reg & ~rgt_oh;
                    eat_next    = eat_reg | rgt_oh;
                end
                head_next = 1'b0;
                priority if (g0_reg && g_cur[rgt_reg])
                begin
                    buf_seat_next[0] = lft_reg;
                    buf_last_next[0] = 1'b0;
                    buf_seat_next[1] = rgt_reg;
                    buf_last_next[1] = 1'b1;
                    out_cnt_next     = 2'd2;
                end
                else if (g0_reg)
                begin
                    buf_seat_next[0] = lft_reg;
                    buf_last_next[0] = 1'b1;
                    out_cnt_next     = 2'd1;
                end
                else if (g_cur[rgt_reg])
                begin
                    buf_seat_next[0] = rgt_reg;
                    buf_last_next[0] = 1'b1;
                    out_cnt_next     = 2'd1;
                end
                else
                begin
                    out_cnt_next = 2'd0;
                end
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            hungry_reg  <= '0;
            eat_reg     <= '0;
            out_cnt_reg <= 2'd0;
            head_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            hungry_reg  <= hungry_next;
            eat_reg     <= eat_next;
            out_cnt_reg <= out_cnt_next;
            head_reg    <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g0_reg          <= g0_next;
        lft_reg         <= lft_next;
        rgt_reg         <= rgt_next;
        nm1_reg         <= nm1_next;
        buf_seat_reg[0] <= buf_seat_next[0];
        buf_seat_reg[1] <= buf_seat_next[1];
        buf_last_reg[0] <= buf_last_next[0];
        buf_last_reg[1] <= buf_last_next[1];
    end

endmodule

`default_nettype wire

### rtl/core/ring_resource_arbiter.sv
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   mode, seat_index
// out       output     out_valid / out_stall granted_seat, last
// cfg       input      seat_count_we         seat_count
//
// A take is done in BK_IDLE; a release adds BK_RIGHT (left test, then right test).
// Results sit in a 2-beat output buffer; the back end starts the next op only once
// that buffer has drained, so no new item starts until the last one's beats are out.
// The 2-entry op queue takes beats until full while the back end works or out stalls.
// Reset clears all seats to thinking at once; there is no clearing pass.
`default_nettype none

module ring_resource_arbiter
    import rra_pkg::*;
#(
    parameter int MAX_SEATS = DEF_MAX_SEATS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               mode,
    input  wire logic [SEAT_W-1:0]  seat_index,
    input  wire logic               seat_count_we,
    input  wire logic [COUNT_W-1:0] seat_count,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [SEAT_W-1:0]       granted_seat,
    output logic                    last
);

    localparam int IDX_W = $clog2(MAX_SEATS);
    localparam int OP_W  = 1 + 4 * IDX_W;

    logic [COUNT_W-1:0] seat_count_reg;
    logic               q_full;
    logic               q_push;
    logic               q_empty;
    logic               q_pop;
    logic [OP_W-1:0]    q_wdata;
    logic [OP_W-1:0]    q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seat_count_reg <= COUNT_RESET;
        end
        else if (seat_count_we)
        begin
            seat_count_reg <= seat_count;
        end
    end

    rra_front #(
        .MAX_SEATS (MAX_SEATS),
        .IDX_W     (IDX_W),
        .OP_W      (OP_W)
    ) u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .seat_index (seat_index),
        .seat_count (seat_count_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    rra_opq #(
        .WIDTH (OP_W),
        .DEPTH (OPQ_DEPTH)
    ) u_opq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_rdata)
    );

    rra_back #(
        .MAX_SEATS (MAX_SEATS),
        .IDX_W     (IDX_W),
        .OP_W      (OP_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (!q_empty),
        .op_data      (q_rdata),
        .op_pop       (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .granted_seat (granted_seat),
        .last         (last)
    );

endmodule

`default_nettype wire

### rtl/core/rra_checker.sv
`default_nettype none
`include "ring_resource_arbiter_defines.svh"

module rra_checker
    import rra_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               mode,
    input wire logic [SEAT_W-1:0]  seat_index,
    input wire logic               seat_count_we,
    input wire logic [COUNT_W-1:0] seat_count,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [SEAT_W-1:0]  granted_seat,
    input wire logic               last
);

    // stalled result beat holds
    `RRA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(granted_seat) && $stable(last))

    // a taken non-final grant is always followed by the final one
    `RRA_ASSERT_NEXT(a_pair_done, clk, rst_n, out_valid && !last && !out_stall,
        out_valid && last)

    // no result straight out of reset
    `RRA_ASSERT_NOW(a_reset_quiet, clk, rst_n, $rose(rst_n), !out_valid)

    // stalled input beat holds
    `RRA_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall,
        in_valid && $stable(mode) && $stable(seat_index))

    // count written only with no beat on either side
    `RRA_ASSERT_NOW(a_cfg_idle, clk, rst_n, seat_count_we,
        !in_valid && !out_valid && !$isunknown(seat_count))

endmodule

bind ring_resource_arbiter rra_checker u_rra_checker (.*);

`default_nettype wire

### tb/ring_resource_arbiter_tb.sv
`default_nettype none

module ring_resource_arbiter_tb;
    import rra_pkg::*;

    localparam int STUCK_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 12;
    localparam int REPORT_MAX = 10;

    typedef enum logic [1:0] {
        SEAT_THINKING = 2'd0,
        SEAT_HUNGRY   = 2'd1,
        SEAT_EATING   = 2'd2
    } seat_state_t;

    typedef struct packed {
        logic [SEAT_W-1:0] seat;
        logic              last;
    } grant_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               mode = MODE_TAKE;
    logic [SEAT_W-1:0]  seat_index = '0;
    logic               seat_count_we = 1'b0;
    logic [COUNT_W-1:0] seat_count = COUNT_RESET;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [SEAT_W-1:0]  granted_seat;
    logic               last;

    // model of the ring, updated on every accepted in-range beat
    seat_state_t        ring_seats [DEF_MAX_SEATS];
    logic [COUNT_W-1:0] ring_count = COUNT_RESET;
    grant_t             grants_due [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int fail_count = 0;
    int stuck_cycles = 0;
    grant_t got_grant;
    grant_t want_grant;

    ring_resource_arbiter i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .seat_index    (seat_index),
        .seat_count_we (seat_count_we),
        .seat_count    (seat_count),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .granted_seat  (granted_seat),
        .last          (last)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        for (int k = 0; k < DEF_MAX_SEATS; k++)
        begin
            ring_seats[k] = SEAT_THINKING;
        end
    end

    function automatic int ring_len();
        int n;
        n = int'(ring_count);
        if (n < MIN_SEATS)
            n = MIN_SEATS;
        if (n > DEF_MAX_SEATS)
            n = DEF_MAX_SEATS;
        return n;
    endfunction

    function automatic logic try_seat(int k, int n);
        int lft;
        int rgt;
        lft = (k + n - 1) % n;
        rgt = (k + 1) % n;
        if (ring_seats[k] == SEAT_HUNGRY && ring_seats[lft] != SEAT_EATING &&
            ring_seats[rgt] != SEAT_EATING)
        begin
            ring_seats[k] = SEAT_EATING;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void predict_grants(logic op, logic [SEAT_W-1:0] s);
        int n;
        int k;
        int lft;
        int rgt;
        int cnt;
        logic [SEAT_W-1:0] won [2];
        grant_t g;
        n = ring_len();
        k = int'(s);
        cnt = 0;
        if (k >= n)
            return;
        if (op == MODE_TAKE)
        begin
            ring_seats[k] = SEAT_HUNGRY;
            if (try_seat(k, n))
            begin
                won[cnt] = SEAT_W'(k);
                cnt++;
            end
        end
        else
        begin
            lft = (k + n - 1) % n;
            rgt = (k + 1) % n;
            ring_seats[k] = SEAT_THINKING;
            if (try_seat(lft, n))
            begin
                won[cnt] = SEAT_W'(lft);
                cnt++;
            end
            if (try_seat(rgt, n))
            begin
                won[cnt] = SEAT_W'(rgt);
                cnt++;
            end
        end
        for (int i = 0; i < cnt; i++)
        begin
            g.seat = won[i];
            g.last = (i == cnt - 1);
            grants_due.push_back(g);
        end
    endfunction

    // predictor and result checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (seat_count_we)
                ring_count = seat_count;
            if (in_valid && !in_stall)
                predict_grants(mode, seat_index);
            if (out_valid && !out_stall)
            begin
                got_grant.seat = granted_seat;
                got_grant.last = last;
                if (grants_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("unexpected grant beat: seat %0d last %0b",
                                 got_grant.seat, got_grant.last);
                end
                else
                begin
                    want_grant = grants_due.pop_front();
                    if (got_grant.seat !== want_grant.seat ||
                        got_grant.last !== want_grant.last)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display("mismatch: exp seat %0d last %0b, got seat %0d last %0b",
                                     want_grant.seat, want_grant.last,
                                     got_grant.seat, got_grant.last);
                    end
                end
            end
        end
    end

    // receiver: random stalls, or a counted hold-off when requested
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // watchdog: cycles without any beat or register write
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || seat_count_we)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_beat(logic op, logic [SEAT_W-1:0] s);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= op;
        seat_index <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // zero-grant ops may still sit in the op queue, hence the extra cycles
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
        begin
            while (grants_due.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
        while (grants_due.size() != 0);
    endtask

    task automatic write_seat_count(logic [COUNT_W-1:0] value);
        wait_drained();
        seat_count_we <= 1'b1;
        seat_count    <= value;
        @(posedge clk);
        seat_count_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0: return 5'd0;
            1: return 5'd1;
            2: return 5'd2;
            3: return 5'd16;
            4: return 5'd31;
            5: return COUNT_W'($urandom_range(17, 31));
            default: return COUNT_W'($urandom_range(2, 16));
        endcase
    endfunction

    // mostly well-formed: eaters release, others ask; some raw noise
    function automatic void pick_item(output logic op, output logic [SEAT_W-1:0] s);
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            op = 1'($urandom_range(0, 1));
            s  = SEAT_W'($urandom_range(0, 15));
        end
        else
        begin
            k = $urandom_range(0, ring_len() - 1);
            s = SEAT_W'(k);
            if (ring_seats[k] == SEAT_EATING)
                op = ($urandom_range(0, 99) < 80) ? MODE_RELEASE : MODE_TAKE;
            else
                op = ($urandom_range(0, 99) < 85) ? MODE_TAKE : MODE_RELEASE;
        end
    endfunction

    task automatic test_directed_grants();
        // default ring of five
        send_beat(MODE_TAKE, 4'd0);
        send_beat(MODE_TAKE, 4'd1);     // blocked by seat 0
        send_beat(MODE_TAKE, 4'd2);
        send_beat(MODE_TAKE, 4'd4);     // blocked by wraparound neighbor 0
        send_beat(MODE_RELEASE, 4'd0);  // wakes seat 4, seat 1 still blocked
        send_beat(MODE_RELEASE, 4'd2);  // wakes seat 1
        send_beat(MODE_TAKE, 4'd1);     // re-take by an eater
        send_beat(MODE_TAKE, 4'd3);     // hungry but blocked
        send_beat(MODE_RELEASE, 4'd3);  // release by a non-eater
        send_beat(MODE_TAKE, 4'd7);     // beyond the ring, ignored
        send_beat(MODE_RELEASE, 4'd15); // ignored
        send_beat(MODE_RELEASE, 4'd4);
        send_beat(MODE_RELEASE, 4'd1);
        // full ring, highest seat; seats 0..4 keep state across the change
        write_seat_count(5'd16);
        send_beat(MODE_TAKE, 4'd15);
        send_beat(MODE_TAKE, 4'd14);
        send_beat(MODE_RELEASE, 4'd15);
        send_beat(MODE_RELEASE, 4'd14);
        // out-of-range counts clamp
        write_seat_count(5'd31);
        send_beat(MODE_TAKE, 4'd8);
        send_beat(MODE_RELEASE, 4'd8);
        write_seat_count(5'd0);
        send_beat(MODE_TAKE, 4'd3);     // ignored on the clamped ring of two
        wait_drained();
    endtask

    task automatic test_two_seat_ring();
        write_seat_count(5'd1);
        send_beat(MODE_RELEASE, 4'd0);
        send_beat(MODE_RELEASE, 4'd1);
        send_beat(MODE_TAKE, 4'd0);
        send_beat(MODE_TAKE, 4'd1);
        // both neighbor tests hit seat 1, granted once
        send_beat(MODE_RELEASE, 4'd0);
        send_beat(MODE_RELEASE, 4'd1);
        wait_drained();
    endtask

    task automatic test_random_traffic(int items, int s_pct, int r_pct);
        logic op;
        logic [SEAT_W-1:0] s;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < items; i++)
        begin
            if (i % 48 == 0)
                write_seat_count(pick_count());
            pick_item(op, s);
            send_beat(op, s);
        end
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        logic op;
        logic [SEAT_W-1:0] s;
        write_seat_count(5'd16);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 300;
        for (int i = 0; i < 40; i++)
        begin
            pick_item(op, s);
            send_beat(op, s);
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_grants();
        test_two_seat_ring();
        test_random_traffic(190, 28, 51);
        test_random_traffic(190, 51, 28);
        test_random_traffic(190, 0, 0);
        test_output_backpressure();

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && grants_due.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
